>>> src/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg: shared types and constants of the ordered list engine
// Request and result structs, request codes, cell control and helper masks.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int CAPACITY       = 16;
  localparam int MAX_ITEM_BYTES = 8;
  localparam int ITEM_W         = 64;
  localparam int IDX_W          = $clog2(CAPACITY);
  localparam int CNT_W          = $clog2(CAPACITY + 1);
  localparam int POS_W          = 5;
  localparam int CMP_W          = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [3:0] ITEM_BYTES_RESET = 4'd8;
  localparam logic       REG_ITEM_BYTES   = 1'b0;

  typedef enum logic [2:0] {
    REQ_APPEND  = 3'd0,
    REQ_INSERT  = 3'd1,
    REQ_REPLACE = 3'd2,
    REQ_REMOVE  = 3'd3,
    REQ_READ    = 3'd4,
    REQ_FIND_1ST = 3'd5,
    REQ_FIND_LAST = 3'd6,
    REQ_CLEAR   = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item_value;
    logic [3:0]        match_bytes;
  } ole_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ITEM_W-1:0] read_value;
    logic              found;
    logic [3:0]        found_index;
    logic [4:0]        entry_count;
  } ole_out_t;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_ctl_t;

  typedef struct packed {
    logic [ITEM_W-1:0] key;
    logic [ITEM_W-1:0] prefix_mask;
    logic [ITEM_W-1:0] full_mask;
  } cell_bcast_t;

  // item_bytes 0 acts as 1, anything above the maximum as the maximum
  function automatic logic [3:0] width_bytes(input logic [3:0] ib);
    logic [3:0] b;
    b = ib;
    if (b == 4'd0) b = 4'd1;
    if (b > 4'(MAX_ITEM_BYTES)) b = 4'(MAX_ITEM_BYTES);
    return b;
  endfunction

  function automatic logic [ITEM_W-1:0] byte_mask(input logic [3:0] nb);
    logic [ITEM_W-1:0] m;
    m = '0;
    for (int b = 0; b < ITEM_W / 8; b++) begin
      m[8*b +: 8] = (4'(b) < nb) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

>>> src/ole_cell.sv
// ----------------------------------------------------------------------------
// ole_cell: one storage cell of the list
// Holds one entry, loads, takes a neighbour's entry, and compares with the key.
// ----------------------------------------------------------------------------
module ole_cell import ole_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  cell_bcast_t       bcast,
  input  logic [ITEM_W-1:0] below,
  input  logic [ITEM_W-1:0] above,
  output logic [ITEM_W-1:0] entry,
  output logic              hit_prefix,
  output logic              hit_full
);

  logic [ITEM_W-1:0] entry_r;
  logic [ITEM_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = bcast.key;
    end else if (ctl.shift_up) begin
      entry_nxt = below;
    end else if (ctl.shift_down) begin
      entry_nxt = above;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry      = entry_r;
  assign hit_prefix = ((entry_r ^ bcast.key) & bcast.prefix_mask) == '0;
  assign hit_full   = ((entry_r ^ bcast.key) & bcast.full_mask) == '0;

endmodule

>>> src/ole_ctrl.sv
// ----------------------------------------------------------------------------
// ole_ctrl: request decode and list control
// Keeps the item count, drives the cells and builds the result of a request.
// ----------------------------------------------------------------------------
module ole_ctrl import ole_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  ole_in_t                        req,
  input  logic [3:0]                     item_bytes,
  input  logic [CAPACITY-1:0][ITEM_W-1:0] entries,
  input  logic [CAPACITY-1:0]            hit_prefix,
  input  logic [CAPACITY-1:0]            hit_full,
  output cell_bcast_t                    bcast,
  output cell_ctl_t [CAPACITY-1:0]       cell_ctl,
  output ole_out_t                       result
);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [3:0]        wb;
  logic [3:0]        mb;
  logic [ITEM_W-1:0] wmask;
  logic              full;
  logic              ok;
  logic [1:0]        status;
  logic [CAPACITY-1:0] valid;
  logic [ITEM_W-1:0] rd;
  logic              found;
  logic [3:0]        fidx;

  assign pos_ext = CMP_W'(req.position);
  assign cnt_ext = CMP_W'(count_r);
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign wb      = width_bytes(item_bytes);
  assign wmask   = byte_mask(wb);
  assign mb      = (req.match_bytes == 4'd0 || req.match_bytes > wb) ? wb : req.match_bytes;

  assign bcast.key         = req.item_value & wmask;
  assign bcast.full_mask   = wmask;
  assign bcast.prefix_mask = byte_mask(mb);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = CMP_W'(i) < cnt_ext;
    end
  end

  // status and count update
  always_comb begin
    status    = ST_OK;
    count_nxt = count_r;
    case (req_e'(req.req_type))
      REQ_APPEND: begin
        if (full) status = ST_FULL;
        else count_nxt = count_r + CNT_W'(1);
      end
      REQ_INSERT: begin
        if (pos_ext > cnt_ext) status = ST_BAD_POS;
        else if (full) status = ST_FULL;
        else count_nxt = count_r + CNT_W'(1);
      end
      REQ_REPLACE, REQ_READ: begin
        if (pos_ext >= cnt_ext) status = ST_BAD_POS;
      end
      REQ_REMOVE: begin
        if (pos_ext >= cnt_ext) status = ST_BAD_POS;
        else count_nxt = count_r - CNT_W'(1);
      end
      REQ_CLEAR: count_nxt = '0;
      default: ;
    endcase
  end

  assign ok = accept && (status == ST_OK);

  // per-cell moves
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctl[i] = '0;
      if (ok) begin
        case (req_e'(req.req_type))
          REQ_APPEND:  cell_ctl[i].load = (CMP_W'(i) == cnt_ext);
          REQ_INSERT: begin
            cell_ctl[i].load     = (CMP_W'(i) == pos_ext);
            cell_ctl[i].shift_up = (CMP_W'(i) > pos_ext) && (CMP_W'(i) <= cnt_ext);
          end
          REQ_REPLACE: cell_ctl[i].load = (CMP_W'(i) == pos_ext);
          REQ_REMOVE:
            cell_ctl[i].shift_down = (CMP_W'(i) >= pos_ext) &&
                                     (CMP_W'(i) + CMP_W'(1) < cnt_ext);
          default: ;
        endcase
      end
    end
  end

  // read mux
  always_comb begin
    rd = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CMP_W'(i) == pos_ext) rd = entries[i] & wmask;
    end
    if (req_e'(req.req_type) != REQ_READ || status != ST_OK) rd = '0;
  end

  // priority search: lowest index for find first, highest for find last
  always_comb begin
    found = 1'b0;
    fidx  = 4'd0;
    case (req_e'(req.req_type))
      REQ_FIND_1ST: begin
        for (int i = CAPACITY - 1; i >= 0; i--) begin
          if (hit_prefix[i] && valid[i]) begin
            found = 1'b1;
            fidx  = 4'(i);
          end
        end
      end
      REQ_FIND_LAST: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (hit_full[i] && valid[i]) begin
            found = 1'b1;
            fidx  = 4'(i);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  assign result.status      = status;
  assign result.read_value  = rd;
  assign result.found       = found;
  assign result.found_index = fidx;
  assign result.entry_count = 5'(count_nxt);

endmodule

>>> src/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine: fixed-capacity ordered list
// Row of storage cells with a compare in each cell, plus request control.
// ----------------------------------------------------------------------------
// Usage:
//   in_ channel carries one request (ole_in_t) per transfer; out_ channel
//   returns exactly one result (ole_out_t) per request, in request order.
//   A transfer happens on a clock edge with valid high and stall low.
//   Every request, including insert and remove with their shifts and both
//   searches, completes in the cell row in the cycle of acceptance: the
//   result is in the output register the cycle after acceptance, and one
//   request per cycle is taken while results are drained.
//   The output register is the only buffer: while a result waits and
//   out_stall is high, in_stall is raised and no request is taken.
//   cfg_ is an APB-style port; item_bytes lies at byte address 0.
//   Write it only while no request is outstanding.
//   Reset (rst_n low, synchronous) empties the list, sets item_bytes to 8
//   and drops out_valid; stored entries are not cleared, as positions at or
//   above the item count are never read.
// ----------------------------------------------------------------------------
module ordered_list_engine import ole_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ole_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ole_out_t              out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic                            accept;
  logic [3:0]                      item_bytes_r;
  logic                            out_valid_r;
  ole_out_t                        out_data_r;
  ole_out_t                        result;
  cell_bcast_t                     bcast;
  cell_ctl_t [CAPACITY-1:0]        cell_ctl;
  logic [CAPACITY-1:0][ITEM_W-1:0] entries;
  logic [CAPACITY-1:0]             hit_prefix;
  logic [CAPACITY-1:0]             hit_full;
  logic                            reg_sel;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // config register
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[CFG_ADDR_W-1] == REG_ITEM_BYTES);
  assign cfg_prdata = reg_sel ? CFG_DATA_W'(item_bytes_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_bytes_r <= ITEM_BYTES_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      item_bytes_r <= cfg_pwdata[3:0];
    end
  end

  ole_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req        (in_data),
    .item_bytes (item_bytes_r),
    .entries    (entries),
    .hit_prefix (hit_prefix),
    .hit_full   (hit_full),
    .bcast      (bcast),
    .cell_ctl   (cell_ctl),
    .result     (result)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ITEM_W-1:0] below;
    logic [ITEM_W-1:0] above;
    if (g == 0) begin : g_first
      assign below = '0;
    end else begin : g_mid_lo
      assign below = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign above = '0;
    end else begin : g_mid_hi
      assign above = entries[g+1];
    end
    ole_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .bcast      (bcast),
      .below      (below),
      .above      (above),
      .entry      (entries[g]),
      .hit_prefix (hit_prefix[g]),
      .hit_full   (hit_full[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/ole_list_checker.sv
// ----------------------------------------------------------------------------
// ole_list_checker: result checker for the ordered list engine
// Follows item_bytes writes on the cfg port, keeps its own copy of the list,
// predicts one result per accepted request and compares results in order.
// ----------------------------------------------------------------------------
module ole_list_checker import ole_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  ole_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  ole_out_t              out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    errors,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] ITEM_BYTES_ADDR = CFG_ADDR_W'(4 * REG_ITEM_BYTES);

  logic [ITEM_W-1:0] list_mem [CAPACITY];
  int                list_len;
  logic [3:0]        width_reg;
  ole_out_t          result_q [$];
  int                fails;
  int                results_seen;

  function automatic logic [ITEM_W-1:0] low_bytes_mask(input int nbytes);
    if (nbytes >= 8) return '1;
    return (64'd1 << (8 * nbytes)) - 64'd1;
  endfunction

  // applies one request to the shadow list and returns the result it gives
  function automatic ole_out_t apply_list_request(input ole_in_t rq);
    ole_out_t          res;
    int                wb;
    int                pb;
    int                pos;
    logic [ITEM_W-1:0] wmask;
    logic [ITEM_W-1:0] pmask;
    logic [ITEM_W-1:0] key;
    res = '0;
    pos = rq.position;
    wb = (width_reg == 4'd0) ? 1 : (width_reg > MAX_ITEM_BYTES) ? MAX_ITEM_BYTES : width_reg;
    wmask = low_bytes_mask(wb);
    key = rq.item_value & wmask;
    case (req_e'(rq.req_type))
      REQ_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_mem[list_len] = key;
          list_len++;
        end
      end
      REQ_INSERT: begin
        // position is checked before fullness
        if (pos > list_len) begin
          res.status = ST_BAD_POS;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = key;
          list_len++;
        end
      end
      REQ_REPLACE: begin
        if (pos >= list_len) res.status = ST_BAD_POS;
        else list_mem[pos] = key;
      end
      REQ_REMOVE: begin
        if (pos >= list_len) begin
          res.status = ST_BAD_POS;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      REQ_READ: begin
        if (pos >= list_len) res.status = ST_BAD_POS;
        else res.read_value = list_mem[pos] & wmask;
      end
      REQ_FIND_1ST: begin
        pb = (rq.match_bytes == 4'd0 || rq.match_bytes > wb) ? wb : rq.match_bytes;
        pmask = low_bytes_mask(pb);
        for (int i = 0; i < list_len; i++) begin
          if (((list_mem[i] ^ key) & pmask) == '0) begin
            res.found = 1'b1;
            res.found_index = 4'(i);
            break;
          end
        end
      end
      REQ_FIND_LAST: begin
        for (int i = list_len - 1; i >= 0; i--) begin
          if (((list_mem[i] ^ key) & wmask) == '0) begin
            res.found = 1'b1;
            res.found_index = 4'(i);
            break;
          end
        end
      end
      REQ_CLEAR: list_len = 0;
      default: ;
    endcase
    res.entry_count = 5'(list_len);
    return res;
  endfunction

  task automatic note_failure(input string msg);
    if (fails < 10) $display("%0t: result %0d: %s", $realtime, results_seen, msg);
    fails++;
  endtask

  always @(posedge clk) begin
    ole_out_t want;
    if (!rst_n) begin
      list_len = 0;
      width_reg = ITEM_BYTES_RESET;
      result_q.delete();
      fails = 0;
      results_seen = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ITEM_BYTES_ADDR)
        width_reg = cfg_pwdata[3:0];
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          note_failure("result with no request outstanding");
        end else begin
          want = result_q.pop_front();
          if (out_data.status !== want.status)
            note_failure($sformatf("status expected %0d got %0d", want.status,
                                   out_data.status));
          if (out_data.read_value !== want.read_value)
            note_failure($sformatf("read_value expected %h got %h", want.read_value,
                                   out_data.read_value));
          if (out_data.found !== want.found)
            note_failure($sformatf("found expected %0d got %0d", want.found,
                                   out_data.found));
          if (out_data.found_index !== want.found_index)
            note_failure($sformatf("found_index expected %0d got %0d", want.found_index,
                                   out_data.found_index));
          if (out_data.entry_count !== want.entry_count)
            note_failure($sformatf("entry_count expected %0d got %0d", want.entry_count,
                                   out_data.entry_count));
        end
        results_seen++;
      end
      if (in_valid && !in_stall) result_q.push_back(apply_list_request(in_data));
    end
    outstanding <= result_q.size();
    errors <= fails;
  end

endmodule

>>> tb/tb_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_engine: top-level testbench of the ordered list engine
// Drives directed then random requests over a range of item widths and
// idle patterns; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;
  import ole_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 80;
  localparam int N_PHASES    = 12;
  localparam logic [CFG_ADDR_W-1:0] ITEM_BYTES_ADDR = CFG_ADDR_W'(4 * REG_ITEM_BYTES);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  ole_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  ole_out_t              out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int                    errors;
  int                    outstanding;
  int                    cycles = 0;
  int                    idle_pct = 30;
  int                    stall_pct = 56;
  logic [ITEM_W-1:0]     value_pool [6];
  logic [3:0]            width_plan [N_PHASES] = '{1, 15, 0, 8, 3, 5, 2, 7, 4, 6, 8, 9};

  ordered_list_engine i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  ole_list_checker u_list_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .errors, .outstanding
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[ordered_list_engine] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && (int'($urandom_range(99)) < stall_pct);
  end

  function automatic ole_in_t pack_request(input req_e t, input int pos,
                                           input logic [ITEM_W-1:0] v, input int mb);
    ole_in_t r;
    r.req_type    = t;
    r.position    = 5'(pos);
    r.item_value  = v;
    r.match_bytes = 4'(mb);
    return r;
  endfunction

  // mostly pool values so that searches hit; some with scrambled upper bytes
  function automatic logic [ITEM_W-1:0] pick_value();
    logic [ITEM_W-1:0] v;
    logic [ITEM_W-1:0] keep;
    int                nb;
    if ($urandom_range(99) < 40) return {$urandom, $urandom};
    v = value_pool[$urandom_range(5)];
    if ($urandom_range(99) < 30) begin
      nb = $urandom_range(1, 7);
      keep = (64'd1 << (8 * nb)) - 64'd1;
      v = (v & keep) | ({$urandom, $urandom} & ~keep);
    end
    return v;
  endfunction

  function automatic ole_in_t random_request();
    int   pick;
    int   pos;
    req_e t;
    pick = $urandom_range(999);
    if (pick < 220)      t = REQ_APPEND;
    else if (pick < 440) t = REQ_INSERT;
    else if (pick < 540) t = REQ_REPLACE;
    else if (pick < 680) t = REQ_REMOVE;
    else if (pick < 800) t = REQ_READ;
    else if (pick < 895) t = REQ_FIND_1ST;
    else if (pick < 990) t = REQ_FIND_LAST;
    else                 t = REQ_CLEAR;
    pos = ($urandom_range(99) < 75) ? $urandom_range(16) : $urandom_range(31);
    return pack_request(t, pos, pick_value(), $urandom_range(15));
  endfunction

  // each cycle before a request goes out is idle with probability idle_pct
  task automatic push_request(input ole_in_t r);
    while (idle_pct != 0 && int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_item_bytes(input logic [3:0] nb);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ITEM_BYTES_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(nb);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    value_pool[0] = '1;
    value_pool[1] = '0;
    for (int i = 2; i < 6; i++) value_pool[i] = {$urandom, $urandom};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, bad positions, shifts, prefix search, full list
    push_request(pack_request(REQ_REMOVE, 0, '0, 0));
    push_request(pack_request(REQ_FIND_LAST, 0, '0, 0));
    push_request(pack_request(REQ_INSERT, 1, 64'h1, 0));
    push_request(pack_request(REQ_INSERT, 0, '1, 0));
    push_request(pack_request(REQ_APPEND, 0, '0, 0));
    push_request(pack_request(REQ_INSERT, 2, 64'h0123_4567_89AB_CDEF, 0));
    push_request(pack_request(REQ_REPLACE, 1, 64'h8000_0000_0000_00FF, 0));
    push_request(pack_request(REQ_READ, 1, '0, 0));
    push_request(pack_request(REQ_FIND_1ST, 0, 64'h0000_0000_0000_00FF, 1));
    push_request(pack_request(REQ_FIND_1ST, 0, 64'h8000_0000_0000_00FF, 15));
    push_request(pack_request(REQ_FIND_LAST, 0, '1, 0));
    for (int i = 0; i < 13; i++) push_request(pack_request(REQ_APPEND, 0, {$urandom, $urandom}, 0));
    push_request(pack_request(REQ_APPEND, 0, '1, 0));
    push_request(pack_request(REQ_INSERT, 17, '1, 0));
    push_request(pack_request(REQ_INSERT, 16, '1, 0));
    push_request(pack_request(REQ_REMOVE, 0, '0, 0));
    push_request(pack_request(REQ_CLEAR, 31, '1, 15));
    push_request(pack_request(REQ_READ, 0, '0, 0));
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 4) begin
        idle_pct = 30;
        stall_pct = 56;
      end else if (p < 8) begin
        idle_pct = 56;
        stall_pct = 30;
      end else begin
        idle_pct = 0;
        stall_pct = 0;
      end
      write_item_bytes(width_plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) push_request(random_request());
      drain();
    end

    if (errors == 0 && outstanding == 0) begin
      $display("[ordered_list_engine] OK");
    end else begin
      $display("[ordered_list_engine] ERROR");
    end
    $finish;
  end

endmodule
